// File: hw/rtl/hdg_pkg.sv
// ----------------------------------------------------------------------------
// hdg_pkg
// Shared types, constants and the arctangent table of the distance gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdg_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 40) ? 40 : CORDIC_ITERATIONS;
    localparam int ROOT_STEPS        = 31;
    localparam int STEP_W            = 6;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int DIST_W = 26;
    localparam int CW     = 36;

    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 31'sd900000000;
    localparam logic signed [33:0]      HALF_TURN = 34'sd1800000000;
    localparam logic signed [33:0]      FULL_TURN = 34'sd3600000000;
    localparam logic [31:0]             DEG_TO_RAD_Q  = 32'd2012227627;
    localparam logic [31:0]             TWO_RADIUS_Q3 = 32'd334435712;
    localparam logic [31:0]             GAIN_INV      = 32'd652032874;
    localparam logic [30:0]             Q30_ONE       = 31'h4000_0000;
    localparam logic [DIST_W-1:0]       MIN_DIST_RESET = 26'd50;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_FIRST,
        OP_PREP,
        OP_MUL_ANGLE,
        OP_LOAD_ROT,
        OP_STEP_ROT,
        OP_MUL_SQ,
        OP_STORE_SQ,
        OP_STORE_COS,
        OP_MUL_CC,
        OP_STORE_CC,
        OP_MUL_A,
        OP_STORE_A,
        OP_LOAD_ROOT,
        OP_STEP_ROOT,
        OP_STORE_ROOT,
        OP_LOAD_VEC,
        OP_STEP_VEC,
        OP_MUL_DIST,
        OP_STORE_DIST
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FIRST,
        ST_PREP,
        ST_ANG_MUL,
        ST_ROT_LOAD,
        ST_ROT,
        ST_SQ_MUL,
        ST_SQ_ST,
        ST_COS_ST,
        ST_CC_MUL,
        ST_CC_ST,
        ST_A_MUL,
        ST_A_ST,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_ROOT_ST,
        ST_VEC_LOAD,
        ST_VEC,
        ST_D_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [1:0]        sel;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic have_fix;
    } t_status;

    function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            6'd0:    v = 30'd843314856;
            6'd1:    v = 30'd497837829;
            6'd2:    v = 30'd263043836;
            6'd3:    v = 30'd133525158;
            6'd4:    v = 30'd67021686;
            6'd5:    v = 30'd33543515;
            6'd6:    v = 30'd16775850;
            6'd7:    v = 30'd8388437;
            6'd8:    v = 30'd4194282;
            6'd9:    v = 30'd2097149;
            6'd10:   v = 30'd1048575;
            6'd11:   v = 30'd524287;
            6'd12:   v = 30'd262143;
            6'd13:   v = 30'd131071;
            6'd14:   v = 30'd65535;
            6'd15:   v = 30'd32767;
            6'd16:   v = 30'd16383;
            6'd17:   v = 30'd8191;
            6'd18:   v = 30'd4095;
            6'd19:   v = 30'd2047;
            6'd20:   v = 30'd1023;
            6'd21:   v = 30'd511;
            6'd22:   v = 30'd255;
            6'd23:   v = 30'd127;
            6'd24:   v = 30'd63;
            6'd25:   v = 30'd31;
            6'd26:   v = 30'd15;
            6'd27:   v = 30'd8;
            6'd28:   v = 30'd4;
            6'd29:   v = 30'd2;
            6'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hdg_ctrl.sv
// ----------------------------------------------------------------------------
// hdg_ctrl
// Sequencer that steps the datapath through one distance computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdg_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  hdg_pkg::t_status    i_status,
    output hdg_pkg::t_cmd       o_cmd
);

    hdg_pkg::t_state                r_state, n_state;
    logic [1:0]                     r_sel, n_sel;
    logic [hdg_pkg::STEP_W-1:0]     r_step, n_step;
    logic                           r_out_valid, n_out_valid;
    logic                           out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hdg_pkg::ST_IDLE;
            r_sel       <= 2'd0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            hdg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.have_fix ? hdg_pkg::ST_PREP : hdg_pkg::ST_FIRST;
                end
            end
            hdg_pkg::ST_FIRST, hdg_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state     = hdg_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            hdg_pkg::ST_PREP: begin
                n_state = hdg_pkg::ST_ANG_MUL;
                n_sel   = 2'd0;
            end
            hdg_pkg::ST_ANG_MUL: n_state = hdg_pkg::ST_ROT_LOAD;
            hdg_pkg::ST_ROT_LOAD: begin
                n_state = hdg_pkg::ST_ROT;
                n_step  = '0;
            end
            hdg_pkg::ST_ROT: begin
                if (r_step == hdg_pkg::STEP_W'(hdg_pkg::CORDIC_STEPS - 1)) begin
                    n_state = r_sel[1] ? hdg_pkg::ST_COS_ST : hdg_pkg::ST_SQ_MUL;
                end else begin
                    n_step = r_step + hdg_pkg::STEP_W'(1);
                end
            end
            hdg_pkg::ST_SQ_MUL: n_state = hdg_pkg::ST_SQ_ST;
            hdg_pkg::ST_SQ_ST: begin
                n_state = hdg_pkg::ST_ANG_MUL;
                n_sel   = r_sel + 2'd1;
            end
            hdg_pkg::ST_COS_ST: begin
                if (r_sel == 2'd3) begin
                    n_state = hdg_pkg::ST_CC_MUL;
                end else begin
                    n_state = hdg_pkg::ST_ANG_MUL;
                    n_sel   = r_sel + 2'd1;
                end
            end
            hdg_pkg::ST_CC_MUL: n_state = hdg_pkg::ST_CC_ST;
            hdg_pkg::ST_CC_ST:  n_state = hdg_pkg::ST_A_MUL;
            hdg_pkg::ST_A_MUL:  n_state = hdg_pkg::ST_A_ST;
            hdg_pkg::ST_A_ST: begin
                n_state = hdg_pkg::ST_ROOT_LOAD;
                n_sel   = 2'd0;
            end
            hdg_pkg::ST_ROOT_LOAD: begin
                n_state = hdg_pkg::ST_ROOT;
                n_step  = '0;
            end
            hdg_pkg::ST_ROOT: begin
                if (r_step == hdg_pkg::STEP_W'(hdg_pkg::ROOT_STEPS - 1)) begin
                    n_state = hdg_pkg::ST_ROOT_ST;
                end else begin
                    n_step = r_step + hdg_pkg::STEP_W'(1);
                end
            end
            hdg_pkg::ST_ROOT_ST: begin
                if (r_sel == 2'd0) begin
                    n_state = hdg_pkg::ST_ROOT_LOAD;
                    n_sel   = 2'd1;
                end else begin
                    n_state = hdg_pkg::ST_VEC_LOAD;
                end
            end
            hdg_pkg::ST_VEC_LOAD: begin
                n_state = hdg_pkg::ST_VEC;
                n_step  = '0;
            end
            hdg_pkg::ST_VEC: begin
                if (r_step == hdg_pkg::STEP_W'(hdg_pkg::CORDIC_STEPS - 1)) begin
                    n_state = hdg_pkg::ST_D_MUL;
                end else begin
                    n_step = r_step + hdg_pkg::STEP_W'(1);
                end
            end
            hdg_pkg::ST_D_MUL: n_state = hdg_pkg::ST_DONE;
            default: n_state = hdg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = r_out_valid;
        o_cmd.op    = hdg_pkg::OP_NONE;
        o_cmd.sel   = r_sel;
        o_cmd.step  = r_step;
        case (r_state)
            hdg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = hdg_pkg::OP_CAPTURE;
                end
            end
            hdg_pkg::ST_FIRST: begin
                if (out_free) begin
                    o_cmd.op = hdg_pkg::OP_FIRST;
                end
            end
            hdg_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.op = hdg_pkg::OP_STORE_DIST;
                end
            end
            hdg_pkg::ST_PREP:      o_cmd.op = hdg_pkg::OP_PREP;
            hdg_pkg::ST_ANG_MUL:   o_cmd.op = hdg_pkg::OP_MUL_ANGLE;
            hdg_pkg::ST_ROT_LOAD:  o_cmd.op = hdg_pkg::OP_LOAD_ROT;
            hdg_pkg::ST_ROT:       o_cmd.op = hdg_pkg::OP_STEP_ROT;
            hdg_pkg::ST_SQ_MUL:    o_cmd.op = hdg_pkg::OP_MUL_SQ;
            hdg_pkg::ST_SQ_ST:     o_cmd.op = hdg_pkg::OP_STORE_SQ;
            hdg_pkg::ST_COS_ST:    o_cmd.op = hdg_pkg::OP_STORE_COS;
            hdg_pkg::ST_CC_MUL:    o_cmd.op = hdg_pkg::OP_MUL_CC;
            hdg_pkg::ST_CC_ST:     o_cmd.op = hdg_pkg::OP_STORE_CC;
            hdg_pkg::ST_A_MUL:     o_cmd.op = hdg_pkg::OP_MUL_A;
            hdg_pkg::ST_A_ST:      o_cmd.op = hdg_pkg::OP_STORE_A;
            hdg_pkg::ST_ROOT_LOAD: o_cmd.op = hdg_pkg::OP_LOAD_ROOT;
            hdg_pkg::ST_ROOT:      o_cmd.op = hdg_pkg::OP_STEP_ROOT;
            hdg_pkg::ST_ROOT_ST:   o_cmd.op = hdg_pkg::OP_STORE_ROOT;
            hdg_pkg::ST_VEC_LOAD:  o_cmd.op = hdg_pkg::OP_LOAD_VEC;
            hdg_pkg::ST_VEC:       o_cmd.op = hdg_pkg::OP_STEP_VEC;
            hdg_pkg::ST_D_MUL:     o_cmd.op = hdg_pkg::OP_MUL_DIST;
            default:               o_cmd.op = hdg_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/hdg_datapath.sv
// ----------------------------------------------------------------------------
// hdg_datapath
// Shared multiplier, CORDIC unit, square root unit and fix storage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdg_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  hdg_pkg::t_cmd                       i_cmd,
    output hdg_pkg::t_status                    o_status,
    input  wire signed [hdg_pkg::LAT_W-1:0]     i_latitude,
    input  wire signed [hdg_pkg::LON_W-1:0]     i_longitude,
    input  wire                                 i_cfg_we,
    input  wire [hdg_pkg::DIST_W-1:0]           i_cfg_wdata,
    output logic [hdg_pkg::DIST_W-1:0]          o_distance_feet,
    output logic                                o_accepted
);

    localparam int CW = hdg_pkg::CW;

    logic                               r_have;
    logic [hdg_pkg::DIST_W-1:0]         r_min;
    logic signed [hdg_pkg::LAT_W-1:0]   r_last_lat, r_new_lat, r_lat1c, r_lat2c;
    logic signed [hdg_pkg::LON_W-1:0]   r_last_lon, r_new_lon;
    logic signed [31:0]                 r_dlat, r_dlon;
    logic [63:0]                        r_prod;
    logic signed [CW-1:0]               r_x, r_y, r_z;
    logic [31:0]                        r_slat2, r_slon2, r_c1, r_c2, r_cc;
    logic [30:0]                        r_a, r_rx, r_ry;
    logic [60:0]                        r_rem, r_res, r_bit;
    logic [hdg_pkg::DIST_W-1:0]         r_dist;
    logic                               r_take;

    logic signed [hdg_pkg::LAT_W-1:0]   lat1c, lat2c;
    logic signed [33:0]                 dlon_raw;
    logic signed [31:0]                 dlon_wrap;
    logic signed [31:0]                 ang_src;
    logic [31:0]                        ang_mag;
    logic [30:0]                        ang_rad;
    logic signed [CW-1:0]               ang_z;
    logic [31:0]                        mul_a, mul_b;
    logic                               mul_en;
    logic signed [CW-1:0]               xs, ys, y_abs, zs;
    logic signed [CW-1:0]               atan_v;
    logic                               dir;
    logic [32:0]                        a_sum;
    logic [30:0]                        root_in;
    logic [60:0]                        trial;
    logic [30:0]                        d_raw;
    logic [hdg_pkg::DIST_W-1:0]         d_sat;
    logic                               store_fix;

    function automatic logic signed [hdg_pkg::LAT_W-1:0] clamp_lat(
        input logic signed [hdg_pkg::LAT_W-1:0] v
    );
        logic signed [hdg_pkg::LAT_W-1:0] r;
        if (v > hdg_pkg::LAT_LIMIT) begin
            r = hdg_pkg::LAT_LIMIT;
        end else if (v < -hdg_pkg::LAT_LIMIT) begin
            r = -hdg_pkg::LAT_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign o_status.have_fix = r_have;
    assign o_distance_feet   = r_dist;
    assign o_accepted        = r_take;

    always_comb begin
        lat1c    = clamp_lat(r_last_lat);
        lat2c    = clamp_lat(r_new_lat);
        dlon_raw = 34'(r_new_lon) - 34'(r_last_lon);
        if (dlon_raw >= hdg_pkg::HALF_TURN) begin
            dlon_wrap = 32'(dlon_raw - hdg_pkg::FULL_TURN);
        end else if (dlon_raw < -hdg_pkg::HALF_TURN) begin
            dlon_wrap = 32'(dlon_raw + hdg_pkg::FULL_TURN);
        end else begin
            dlon_wrap = 32'(dlon_raw);
        end
    end

    always_comb begin
        case (i_cmd.sel)
            2'd0:    ang_src = r_dlat;
            2'd1:    ang_src = r_dlon;
            2'd2:    ang_src = 32'(r_lat1c);
            default: ang_src = 32'(r_lat2c);
        endcase
        ang_mag = ang_src[31] ? 32'(-ang_src) : 32'(ang_src);
        ang_rad = i_cmd.sel[1] ? r_prod[60:30] : r_prod[61:31];
        ang_z   = ang_src[31] ? -$signed({5'd0, ang_rad}) : $signed({5'd0, ang_rad});
    end

    always_comb begin
        y_abs  = r_y[CW-1] ? -r_y : r_y;
        zs     = r_z[CW-1] ? '0 : r_z;
        mul_en = 1'b1;
        case (i_cmd.op)
            hdg_pkg::OP_MUL_ANGLE: begin
                mul_a = ang_mag;
                mul_b = hdg_pkg::DEG_TO_RAD_Q;
            end
            hdg_pkg::OP_MUL_SQ: begin
                mul_a = y_abs[31:0];
                mul_b = y_abs[31:0];
            end
            hdg_pkg::OP_MUL_CC: begin
                mul_a = r_c1;
                mul_b = r_c2;
            end
            hdg_pkg::OP_MUL_A: begin
                mul_a = r_cc;
                mul_b = r_slon2;
            end
            hdg_pkg::OP_MUL_DIST: begin
                mul_a = zs[31:0];
                mul_b = hdg_pkg::TWO_RADIUS_Q3;
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        xs     = r_x >>> i_cmd.step;
        ys     = r_y >>> i_cmd.step;
        atan_v = $signed({{(CW - 30){1'b0}}, hdg_pkg::atan_q30(i_cmd.step)});
        dir    = (i_cmd.op == hdg_pkg::OP_STEP_ROT) ? !r_z[CW-1] : !(r_y > 0);
        a_sum  = {1'b0, r_slat2} + {1'b0, r_prod[61:30]};
        root_in = (i_cmd.sel == 2'd0) ? r_a : (hdg_pkg::Q30_ONE - r_a);
        trial  = r_res + r_bit;
        d_raw  = r_prod[63:33];
        d_sat  = (|d_raw[30:hdg_pkg::DIST_W]) ? '1 : d_raw[hdg_pkg::DIST_W-1:0];
        store_fix = (i_cmd.op == hdg_pkg::OP_FIRST) ||
                    ((i_cmd.op == hdg_pkg::OP_STORE_DIST) && (d_sat >= r_min));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_min      <= hdg_pkg::MIN_DIST_RESET;
            r_last_lat <= '0;
            r_last_lon <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            if (store_fix) begin
                r_have     <= 1'b1;
                r_last_lat <= r_new_lat;
                r_last_lon <= r_new_lon;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        case (i_cmd.op)
            hdg_pkg::OP_CAPTURE: begin
                r_new_lat <= i_latitude;
                r_new_lon <= i_longitude;
            end
            hdg_pkg::OP_FIRST: begin
                r_dist <= '0;
                r_take <= 1'b1;
            end
            hdg_pkg::OP_PREP: begin
                r_lat1c <= lat1c;
                r_lat2c <= lat2c;
                r_dlat  <= 32'(lat2c) - 32'(lat1c);
                r_dlon  <= dlon_wrap;
            end
            hdg_pkg::OP_LOAD_ROT: begin
                r_x <= $signed({{(CW - 32){1'b0}}, hdg_pkg::GAIN_INV});
                r_y <= '0;
                r_z <= ang_z;
            end
            hdg_pkg::OP_STEP_ROT, hdg_pkg::OP_STEP_VEC: begin
                if (dir) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end
            end
            hdg_pkg::OP_STORE_SQ: begin
                if (i_cmd.sel == 2'd0) begin
                    r_slat2 <= r_prod[61:30];
                end else begin
                    r_slon2 <= r_prod[61:30];
                end
            end
            hdg_pkg::OP_STORE_COS: begin
                if (i_cmd.sel == 2'd2) begin
                    r_c1 <= r_x[CW-1] ? 32'd0 : r_x[31:0];
                end else begin
                    r_c2 <= r_x[CW-1] ? 32'd0 : r_x[31:0];
                end
            end
            hdg_pkg::OP_STORE_CC: r_cc <= r_prod[61:30];
            hdg_pkg::OP_STORE_A: begin
                r_a <= (a_sum > 33'(hdg_pkg::Q30_ONE)) ? hdg_pkg::Q30_ONE : a_sum[30:0];
            end
            hdg_pkg::OP_LOAD_ROOT: begin
                r_rem <= {root_in, 30'd0};
                r_res <= '0;
                r_bit <= {1'b1, 60'd0};
            end
            hdg_pkg::OP_STEP_ROOT: begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            hdg_pkg::OP_STORE_ROOT: begin
                if (i_cmd.sel == 2'd0) begin
                    r_ry <= r_res[30:0];
                end else begin
                    r_rx <= r_res[30:0];
                end
            end
            hdg_pkg::OP_LOAD_VEC: begin
                r_x <= $signed({{(CW - 31){1'b0}}, r_rx});
                r_y <= $signed({{(CW - 31){1'b0}}, r_ry});
                r_z <= '0;
            end
            hdg_pkg::OP_STORE_DIST: begin
                r_dist <= d_sat;
                r_take <= d_sat >= r_min;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/haversine_distance_gate_top.sv
// The first fix after reset goes from ST_IDLE through ST_FIRST straight to its result.
// Later fixes pass through the shared CORDIC unit (four sin/cos runs, one atan2 run) and
// two 31-step square roots. One fix is processed at a time, so no beat is taken until the
// previous fix has its result; the next beat is taken while a result still waits.
// Reset is synchronous, active low, and clears the stored fix and sets the minimum
// distance to 50 feet.
// ----------------------------------------------------------------------------
// haversine_distance_gate_top
// Great-circle distance gate that keeps the last fix far enough from its predecessor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module haversine_distance_gate_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // latitude [30:0], longitude [62:31], zero [63]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // distance_feet [25:0], zero [31:26]
    output logic        m_axis_tuser,   // accepted [0]
    input  wire         i_cfg_we,
    input  wire  [25:0] i_cfg_wdata
);

    hdg_pkg::t_cmd                  cmd;
    hdg_pkg::t_status               status;
    logic [hdg_pkg::DIST_W-1:0]     distance_feet;

    hdg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hdg_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_latitude      (s_axis_tdata[30:0]),
        .i_longitude     (s_axis_tdata[62:31]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_distance_feet (distance_feet),
        .o_accepted      (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, distance_feet};

endmodule

`default_nettype wire

// File: hw/rtl/hdg_checker.sv
// ----------------------------------------------------------------------------
// hdg_checker
// Port-level checks of the distance gate, attached to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdg_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [31:0] m_axis_tdata,
    input  wire         m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a fix is in progress");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a fix in progress");

endmodule

bind haversine_distance_gate_top hdg_checker u_hdg_checker (.*);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the distance gate against a fixed-point haversine predictor.
// Directed fixes hit the poles, out-of-range latitudes, longitude wrap and a
// distance equal to the threshold. Random tracks of nearby fixes, far jumps
// and raw bit patterns then run under several threshold settings, with the sender,
// the receiver or both idling at random in some phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit [hdg_pkg::DIST_W-1:0] feet;
        bit                       taken;
    } t_gate_verdict;

    class fix_gate_book;
        bit [hdg_pkg::DIST_W-1:0]        min_feet;
        bit                              have_fix;
        bit signed [hdg_pkg::LAT_W-1:0]  last_lat;
        bit signed [hdg_pkg::LON_W-1:0]  last_lon;
        t_gate_verdict                   pending[$];
        int                              mismatches;
        int                              results_seen;
        int                              taken_count;
        longint                          atan_tab[40];

        function new();
            atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                         16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                         131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                         127, 63, 31, 15, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            min_feet = hdg_pkg::MIN_DIST_RESET;
            have_fix = 0;
            last_lat = '0;
            last_lon = '0;
        endfunction

        function longint to_rad(longint u, int sh);
            bit [63:0] m;
            longint r;
            m = (u < 0) ? -u : u;
            r = longint'((m * 64'd2012227627) >> sh);
            return (u < 0) ? -r : r;
        endfunction

        function void rotate(longint ang, output longint s, output longint c);
            longint x, y, z, xs, ys;
            x = 652032874;
            y = 0;
            z = ang;
            for (int i = 0; i < hdg_pkg::CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end else begin
                    x += ys; y -= xs; z += atan_tab[i];
                end
            end
            s = y;
            c = x;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z, xs, ys;
            z = 0;
            for (int i = 0; i < hdg_pkg::CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_tab[i];
                end else begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
            end
            return (z < 0) ? 0 : z;
        endfunction

        function bit [63:0] root(bit [63:0] v);
            bit [63:0] rem, res, b;
            rem = v << 30;
            res = 0;
            b = 64'd1 << 60;
            while (b != 0) begin
                if (rem >= res + b) begin
                    rem -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function bit [63:0] squared(longint v);
            bit [63:0] m;
            m = (v < 0) ? -v : v;
            return (m * m) >> 30;
        endfunction

        function longint pole_clamp(longint v);
            if (v > 900000000) return 900000000;
            if (v < -900000000) return -900000000;
            return v;
        endfunction

        function bit [hdg_pkg::DIST_W-1:0] feet_between(longint lat1, longint lon1,
                                                       longint lat2, longint lon2);
            longint dlat, dlon, s, c1, c2, junk, z;
            bit [63:0] slat, slon, cc, a, d;
            lat1 = pole_clamp(lat1);
            lat2 = pole_clamp(lat2);
            dlat = lat2 - lat1;
            dlon = lon2 - lon1;
            while (dlon >= 64'sd1800000000) dlon -= 64'sd3600000000;
            while (dlon < -64'sd1800000000) dlon += 64'sd3600000000;
            rotate(to_rad(dlat, 31), s, junk);
            slat = squared(s);
            rotate(to_rad(dlon, 31), s, junk);
            slon = squared(s);
            rotate(to_rad(lat1, 30), junk, c1);
            rotate(to_rad(lat2, 30), junk, c2);
            if (c1 < 0) c1 = 0;
            if (c2 < 0) c2 = 0;
            cc = (64'(c1) * 64'(c2)) >> 30;
            a = slat + ((cc * slon) >> 30);
            if (a > 64'd1073741824) a = 64'd1073741824;
            z = vector_angle(longint'(root(a)), longint'(root(64'd1073741824 - a)));
            d = (64'(z) * 64'd334435712) >> 33;
            return (d > 64'h3FFFFFF) ? 26'h3FFFFFF : d[hdg_pkg::DIST_W-1:0];
        endfunction

        function bit [hdg_pkg::DIST_W-1:0] feet_from_last(
            bit signed [hdg_pkg::LAT_W-1:0] lat, bit signed [hdg_pkg::LON_W-1:0] lon);
            return feet_between(longint'(last_lat), longint'(last_lon),
                                longint'(lat), longint'(lon));
        endfunction

        function void note_fix(bit signed [hdg_pkg::LAT_W-1:0] lat,
                               bit signed [hdg_pkg::LON_W-1:0] lon);
            t_gate_verdict v;
            v.feet = 0;
            v.taken = 1;
            if (have_fix) begin
                v.feet = feet_from_last(lat, lon);
                v.taken = (v.feet >= min_feet);
            end
            if (v.taken) begin
                have_fix = 1;
                last_lat = lat;
                last_lon = lon;
            end
            pending.push_back(v);
        endfunction

        function void check_result(bit [31:0] data, bit flag);
            t_gate_verdict v;
            results_seen++;
            if (flag) taken_count++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat distance=%0d accepted=%0b",
                             data[hdg_pkg::DIST_W-1:0], flag);
                return;
            end
            v = pending.pop_front();
            if (data !== {6'd0, v.feet} || flag !== v.taken) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: distance exp %0d got %0d, accepted exp %0b got %0b",
                             v.feet, data, v.taken, flag);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we;
    logic [25:0] i_cfg_wdata;

    fix_gate_book book;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles = 0;
    int           fixes_sent;
    int           cfg_writes;

    haversine_distance_gate_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000) begin
            $display("haversine_distance_gate_top test failed");
            $finish;
        end
    end

    task automatic send_fix(bit signed [hdg_pkg::LAT_W-1:0] lat,
                            bit signed [hdg_pkg::LON_W-1:0] lon);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {1'b0, lon, lat};
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_fix(lat, lon);
        fixes_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_min(bit [hdg_pkg::DIST_W-1:0] feet);
        drain();
        repeat (220) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= feet;
        @(posedge i_clk);
        i_cfg_we <= 0;
        book.min_feet = feet;
        cfg_writes++;
    endtask

    task automatic random_fix();
        int pick;
        int span;
        longint lat, lon;
        pick = $urandom_range(99);
        if (pick < 70) begin
            span = 1 << $urandom_range(14);
            lat = longint'(book.last_lat) + $urandom_range(2 * span) - span;
            lon = longint'(book.last_lon) + $urandom_range(2 * span) - span;
            send_fix(lat[hdg_pkg::LAT_W-1:0], lon[hdg_pkg::LON_W-1:0]);
        end else if (pick < 85) begin
            lat = longint'($urandom_range(32'd1800000000)) - 900000000;
            lon = longint'($urandom_range(32'd3600000000)) - 1800000000;
            send_fix(lat[hdg_pkg::LAT_W-1:0], lon[hdg_pkg::LON_W-1:0]);
        end else begin
            send_fix($urandom(), $urandom());
        end
    endtask

    initial begin
        bit [hdg_pkg::DIST_W-1:0] tie_feet;
        book = new();
        i_rst_n        = 0;
        s_axis_tvalid  = 0;
        s_axis_tdata   = '0;
        i_cfg_we       = 0;
        i_cfg_wdata    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed fixes under the reset threshold.
        send_fix(0, 0);
        send_fix(0, 0);
        send_fix(0, 20);
        send_fix(900000000, 0);
        send_fix(-900000000, 1799999999);
        send_fix(31'sh3FFFFFFF, 32'sh7FFFFFFF);
        send_fix(31'sh40000000, 32'sh80000000);
        send_fix(0, -1800000000);
        send_fix(0, 1800000000);
        send_fix(-899999999, 0);
        send_fix(450000000, -900000000);
        send_fix(-450000000, 900000000);
        drain();

        // A distance equal to the threshold must pass.
        write_min(0);
        send_fix(100000, 100000);
        tie_feet = book.feet_from_last(100300, 99500);
        write_min(tie_feet);
        send_fix(100300, 99500);
        send_fix(100301, 99500);
        write_min(26'h3FFFFFF);
        send_fix(-900000000, 0);
        send_fix(900000000, -1800000000);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_min(50);
                1: write_min(0);
                2: write_min($urandom_range(300, 3000));
                3: write_min(26'h3FFFFFF);
                default: write_min($urandom_range(20, 200));
            endcase
            send_idle_pct  = (phase % 4 == 1 || phase % 4 == 3) ? 48 : 0;
            recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? 48 : 0;
            if (phase == 3) begin
                send_idle_pct  = 10;
                recv_stall_pct = 10;
            end
            for (int n = 0; n < 245; n++) begin
                random_fix();
                if (n == 120) drain();
            end
        end

        drain();
        repeat (250) @(posedge i_clk);
        $display("Sent %0d fixes; %0d results checked, %0d accepted into the store.",
                 fixes_sent, book.results_seen, book.taken_count);
        $display("Threshold written %0d times, with idle and stall rates from 0 to 48%%.",
                 cfg_writes);
        if (book.mismatches == 0 && book.pending.size() == 0) begin
            $display("haversine_distance_gate_top test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", book.mismatches,
                     book.pending.size());
            $display("haversine_distance_gate_top test failed");
        end
        $finish;
    end
endmodule
